/* hw/rtl/dos_pkg.sv */
package dos_pkg;

    // option codes of interest
    localparam logic [7:0] CODE_PAD      = 8'h00;
    localparam logic [7:0] CODE_END      = 8'hff;
    localparam logic [7:0] CODE_MSG_TYPE = 8'h35;
    localparam logic [7:0] CODE_OVERLOAD = 8'h34;
    localparam logic [7:0] CODE_ROUTER   = 8'h03;
    localparam logic [7:0] CODE_DNS      = 8'h06;
    localparam logic [7:0] CODE_SERVER   = 8'h36;

    localparam logic KIND_ADDRESS = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] address;
        logic [7:0]  message_type;
        logic [7:0]  overload_value;
        logic        run_last;
    } dos_result_t;

    typedef enum logic [1:0] {
        OPT_SKIP     = 2'd0,
        OPT_TYPE     = 2'd1,
        OPT_OVERLOAD = 2'd2,
        OPT_ADDR     = 2'd3
    } dos_opt_kind_t;

endpackage

/* hw/rtl/dos_scan.sv */
module dos_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [7:0]         data_byte,
    input  logic               area_start,
    input  logic               area_last,
    output dos_pkg::dos_result_t res0,
    output dos_pkg::dos_result_t res1,
    output logic [1:0]         res_count
);
    import dos_pkg::*;

    typedef enum logic [3:0] {
        PH_CODE = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_DATA = 4'b0100,
        PH_DONE = 4'b1000
    } phase_t;

    phase_t        phase_reg, phase_next;
    dos_opt_kind_t kind_reg, kind_next;
    logic [7:0]    remain_reg, remain_next;
    logic          first_reg, first_next;
    logic [23:0]   word_reg, word_next;
    logic [1:0]    wcnt_reg, wcnt_next;
    logic [7:0]    type_reg, type_next;
    logic [7:0]    ovl_reg, ovl_next;

    logic          addr_v;
    logic          sum_v;
    logic [31:0]   addr_val;

    always_comb
    begin
        // area_start clears everything before the byte is scanned
        phase_next  = area_start ? PH_CODE  : phase_reg;
        kind_next   = area_start ? OPT_SKIP : kind_reg;
        remain_next = area_start ? 8'd0     : remain_reg;
        first_next  = area_start ? 1'b0     : first_reg;
        word_next   = area_start ? 24'd0    : word_reg;
        wcnt_next   = area_start ? 2'd0     : wcnt_reg;
        type_next   = area_start ? 8'd0     : type_reg;
        ovl_next    = area_start ? 8'd0     : ovl_reg;
        addr_v      = 1'b0;
        sum_v       = 1'b0;
        addr_val    = {word_next, data_byte};

        unique case (phase_next)
            PH_CODE:
            begin
                if (data_byte == CODE_END) begin
                    phase_next = PH_DONE;
                end
                else if (data_byte != CODE_PAD) begin
                    if (data_byte == CODE_MSG_TYPE)
                        kind_next = OPT_TYPE;
                    else if (data_byte == CODE_OVERLOAD)
                        kind_next = OPT_OVERLOAD;
                    else if (data_byte == CODE_ROUTER || data_byte == CODE_DNS
                             || data_byte == CODE_SERVER)
                        kind_next = OPT_ADDR;
                    else
                        kind_next = OPT_SKIP;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                remain_next = data_byte;
                first_next  = 1'b1;
                word_next   = 24'd0;
                wcnt_next   = 2'd0;
                phase_next  = (data_byte == 8'd0) ? PH_CODE : PH_DATA;
            end
            PH_DATA:
            begin
                if (kind_next == OPT_TYPE && first_next)
                    type_next = data_byte;
                else if (kind_next == OPT_OVERLOAD && first_next)
                    ovl_next = data_byte;
                else if (kind_next == OPT_ADDR) begin
                    if (wcnt_next == 2'd3) begin
                        addr_v    = 1'b1;
                        word_next = 24'd0;
                        wcnt_next = 2'd0;
                    end
                    else begin
                        word_next = {word_next[15:0], data_byte};
                        wcnt_next = wcnt_next + 2'd1;
                    end
                end
                first_next  = 1'b0;
                remain_next = remain_next - 8'd1;
                if (remain_next == 8'd0) begin
                    phase_next = PH_CODE;
                    word_next  = 24'd0;
                    wcnt_next  = 2'd0;
                end
            end
            default:
            begin
                // scan finished: bytes are ignored until a new area starts
            end
        endcase

        if (phase_reg != PH_DONE || area_start) begin
            if (area_last && phase_next != PH_DONE) begin
                phase_next = PH_DONE;
                sum_v      = 1'b1;
            end
            else if (phase_next == PH_DONE && data_byte == CODE_END) begin
                sum_v = 1'b1;
            end
        end
    end

    always_comb
    begin
        dos_result_t a_res;
        dos_result_t s_res;
        a_res = '{result_kind: KIND_ADDRESS, address: addr_val, message_type: 8'd0,
                  overload_value: 8'd0, run_last: ~sum_v};
        s_res = '{result_kind: KIND_SUMMARY, address: 32'd0, message_type: type_next,
                  overload_value: ovl_next, run_last: 1'b1};
        res0      = addr_v ? a_res : s_res;
        res1      = s_res;
        res_count = {1'b0, addr_v} + {1'b0, sum_v};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_CODE;
            kind_reg   <= OPT_SKIP;
            remain_reg <= 8'd0;
            first_reg  <= 1'b0;
            word_reg   <= 24'd0;
            wcnt_reg   <= 2'd0;
            type_reg   <= 8'd0;
            ovl_reg    <= 8'd0;
        end
        else if (go) begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            remain_reg <= remain_next;
            first_reg  <= first_next;
            word_reg   <= word_next;
            wcnt_reg   <= wcnt_next;
            type_reg   <= type_next;
            ovl_reg    <= ovl_next;
        end
    end

endmodule

/* hw/rtl/dos_result_fifo.sv */
module dos_result_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           push_count,
    input  dos_pkg::dos_result_t push0,
    input  dos_pkg::dos_result_t push1,
    output logic                 room_two,
    output logic                 pop_valid,
    input  logic                 pop,
    output dos_pkg::dos_result_t head
);
    import dos_pkg::*;

    localparam int Depth = 4;
    localparam int PtrW  = $clog2(Depth);

    dos_result_t         entry_reg [Depth];
    logic [PtrW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]       count_reg, count_next;
    logic [PtrW-1:0]     wr_ptr_1;

    assign wr_ptr_1  = wr_ptr_reg + PtrW'(1);
    assign room_two  = count_reg <= (PtrW+1)'(Depth - 2);
    assign pop_valid = count_reg != '0;
    assign head      = entry_reg[rd_ptr_reg];

    assign count_next = count_reg + {{(PtrW-1){1'b0}}, push_count}
                        - {{PtrW{1'b0}}, pop};

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            entry_reg[wr_ptr_reg] <= push0;
        if (push_count == 2'd2)
            entry_reg[wr_ptr_1] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_reg + PtrW'(push_count);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            count_reg <= count_next;
        end
    end

endmodule

/* hw/rtl/dhcp_option_scanner_core.sv */
// DHCP option area scanner. Takes one option-area byte per cycle while
// in_stall is low and emits address results (options 3, 6, 54, one per
// complete 4-byte group) and a summary with message type and overload when
// the area ends. A byte is held in an input register and scanned once the
// result queue has room for two results; its results land in that
// four-entry result queue, whose head drives out_valid and the outputs. A
// byte that yields both an address and the summary pushes two queue
// entries, and in_stall rises when a byte waits in the input register while
// the queue holds more than two results.
module dhcp_option_scanner_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        area_start,
    input  logic        area_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [31:0] address,
    output logic [7:0]  message_type,
    output logic [7:0]  overload_value,
    output logic        run_last
);
    import dos_pkg::*;

    logic        item_valid_reg;
    logic [7:0]  byte_reg;
    logic        start_reg;
    logic        last_reg;
    logic        scan_go;
    logic        room_two;
    logic        in_xfer;
    logic [1:0]  scan_count;
    logic [1:0]  push_count;
    dos_result_t res0, res1, head;

    assign scan_go  = item_valid_reg && room_two;
    assign in_stall = item_valid_reg && !room_two;
    assign in_xfer  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_xfer)
            item_valid_reg <= 1'b1;
        else if (scan_go)
            item_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer) begin
            byte_reg  <= data_byte;
            start_reg <= area_start;
            last_reg  <= area_last;
        end
    end

    dos_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (scan_go),
        .data_byte  (byte_reg),
        .area_start (start_reg),
        .area_last  (last_reg),
        .res0       (res0),
        .res1       (res1),
        .res_count  (scan_count)
    );

    assign push_count = scan_go ? scan_count : 2'd0;

    dos_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .room_two   (room_two),
        .pop_valid  (out_valid),
        .pop        (out_valid && !out_stall),
        .head       (head)
    );

    assign result_kind    = head.result_kind;
    assign address        = head.address;
    assign message_type   = head.message_type;
    assign overload_value = head.overload_value;
    assign run_last       = head.run_last;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import dos_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_ITEMS = 1500;
    localparam int MAX_REPORTS  = 40;

    typedef enum logic [2:0] {
        SCAN_CODE,
        SCAN_LEN,
        SCAN_DATA,
        SCAN_DONE
    } scan_phase_t;

    typedef enum logic [1:0] {
        RX_NONE,
        RX_LIGHT,
        RX_PATTERN,
        RX_HEAVY
    } rx_mode_t;

    typedef enum logic [1:0] {
        END_MARKED,
        END_THEN_TAIL,
        END_CUT_SHORT,
        END_OPEN
    } area_ending_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        area_start = 1'b0;
    logic        area_last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        result_kind;
    logic [31:0] address;
    logic [7:0]  message_type;
    logic [7:0]  overload_value;
    logic        run_last;

    // scanner model state
    scan_phase_t   walk_phase = SCAN_CODE;
    dos_opt_kind_t cur_kind = OPT_SKIP;
    logic [7:0]    data_left = '0;
    logic          first_pending = 1'b0;
    logic [23:0]   group_bytes = '0;
    logic [1:0]    group_fill = '0;
    logic [7:0]    seen_type = '0;
    logic [7:0]    seen_overload = '0;

    dos_result_t pending_scan_results[$];
    logic [7:0]  area_bytes[$];

    int error_count = 0;
    int cycle_count = 0;
    int scanned_bytes = 0;
    int areas_sent = 0;
    int address_results = 0;
    int summary_results = 0;
    int stalled_input_cycles = 0;

    // sender and receiver idling controls
    bit       gaps_enabled = 1'b1;
    int       burst_left = 0;
    rx_mode_t rx_mode = RX_NONE;
    int       rx_tick = 0;
    int       hold_requests = 0;
    int       holds_served = 0;
    int       hold_left = 0;

    dhcp_option_scanner_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .area_start     (area_start),
        .area_last      (area_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .address        (address),
        .message_type   (message_type),
        .overload_value (overload_value),
        .run_last       (run_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (in_valid && in_stall)
            stalled_input_cycles++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_scan_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_REPORTS)
            $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic add_expected(input dos_result_t r);
        pending_scan_results = {pending_scan_results, r};
    endtask

    task automatic add_area_byte(input logic [7:0] b);
        area_bytes = {area_bytes, b};
    endtask

    // Walks one option-area byte and queues the results it should produce.
    task automatic scan_area_byte(input logic [7:0] b, input logic s, input logic l,
                                  output bit taken);
        logic        have_addr;
        logic        have_summary;
        logic [31:0] addr_word;
        dos_result_t r;
        have_addr = 1'b0;
        have_summary = 1'b0;
        addr_word = '0;
        taken = 1'b0;
        if (s)
        begin
            walk_phase = SCAN_CODE;
            cur_kind = OPT_SKIP;
            data_left = '0;
            first_pending = 1'b0;
            group_bytes = '0;
            group_fill = '0;
            seen_type = '0;
            seen_overload = '0;
        end
        if (walk_phase == SCAN_DONE)
            return;
        taken = 1'b1;
        case (walk_phase)
            SCAN_CODE:
            begin
                if (b == CODE_END)
                    walk_phase = SCAN_DONE;
                else if (b != CODE_PAD)
                begin
                    if (b == CODE_MSG_TYPE)
                        cur_kind = OPT_TYPE;
                    else if (b == CODE_OVERLOAD)
                        cur_kind = OPT_OVERLOAD;
                    else if (b == CODE_ROUTER || b == CODE_DNS || b == CODE_SERVER)
                        cur_kind = OPT_ADDR;
                    else
                        cur_kind = OPT_SKIP;
                    walk_phase = SCAN_LEN;
                end
            end
            SCAN_LEN:
            begin
                data_left = b;
                first_pending = 1'b1;
                group_bytes = '0;
                group_fill = '0;
                walk_phase = (b == 8'd0) ? SCAN_CODE : SCAN_DATA;
            end
            default:
            begin
                if (cur_kind == OPT_TYPE && first_pending)
                    seen_type = b;
                else if (cur_kind == OPT_OVERLOAD && first_pending)
                    seen_overload = b;
                else if (cur_kind == OPT_ADDR)
                begin
                    if (group_fill == 2'd3)
                    begin
                        have_addr = 1'b1;
                        addr_word = {group_bytes, b};
                        group_bytes = '0;
                        group_fill = '0;
                    end
                    else
                    begin
                        group_bytes = {group_bytes[15:0], b};
                        group_fill = group_fill + 2'd1;
                    end
                end
                first_pending = 1'b0;
                data_left = data_left - 8'd1;
                if (data_left == 8'd0)
                begin
                    // partial group at the end of the option is dropped
                    walk_phase = SCAN_CODE;
                    group_bytes = '0;
                    group_fill = '0;
                end
            end
        endcase
        if (l && walk_phase != SCAN_DONE)
        begin
            walk_phase = SCAN_DONE;
            have_summary = 1'b1;
        end
        else if (walk_phase == SCAN_DONE && b == CODE_END)
            have_summary = 1'b1;
        if (have_addr)
        begin
            r = '0;
            r.result_kind = KIND_ADDRESS;
            r.address = addr_word;
            r.run_last = !have_summary;
            add_expected(r);
        end
        if (have_summary)
        begin
            r = '0;
            r.result_kind = KIND_SUMMARY;
            r.message_type = seen_type;
            r.overload_value = seen_overload;
            r.run_last = 1'b1;
            add_expected(r);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        dos_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_scan_results.size() == 0)
                report_mismatch("result with nothing pending, address", address, 32'd0);
            else
            begin
                want = pending_scan_results.pop_front();
                if (result_kind !== want.result_kind)
                    report_mismatch("result_kind", 32'(result_kind),
                                    32'(want.result_kind));
                if (address !== want.address)
                    report_mismatch("address", address, want.address);
                if (message_type !== want.message_type)
                    report_mismatch("message_type", 32'(message_type),
                                    32'(want.message_type));
                if (overload_value !== want.overload_value)
                    report_mismatch("overload_value", 32'(overload_value),
                                    32'(want.overload_value));
                if (run_last !== want.run_last)
                    report_mismatch("run_last", 32'(run_last), 32'(want.run_last));
                if (want.result_kind == KIND_SUMMARY)
                    summary_results++;
                else
                    address_results++;
            end
        end
    end

    // receiver: long hold-offs on request, otherwise the current stall mode
    always @(negedge clk)
    begin : receiver
        if (hold_requests != holds_served)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        rx_tick++;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            case (rx_mode)
                RX_LIGHT:   out_stall <= ($urandom_range(0, 99) < 25);
                RX_PATTERN: out_stall <= ((rx_tick % 7) < 3);
                RX_HEAVY:   out_stall <= ($urandom_range(0, 99) < 70);
                default:    out_stall <= 1'b0;
            endcase
        end
    end

    // Called at a falling edge; returns at a falling edge after the transfer.
    task automatic send_area_byte(input logic [7:0] b, input logic s, input logic l);
        bit taken;
        int gap;
        data_byte <= b;
        area_start <= s;
        area_last <= l;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        scan_area_byte(b, s, l, taken);
        if (taken)
            scanned_bytes++;
        @(negedge clk);
        if (gaps_enabled)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 12);
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            else
                burst_left--;
        end
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (pending_scan_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic add_random_option();
        int         pick;
        int         len;
        logic [7:0] code;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            repeat ($urandom_range(1, 3)) add_area_byte(CODE_PAD);
            return;
        end
        if (pick < 25 || pick < 37)
        begin
            code = (pick < 25) ? CODE_MSG_TYPE : CODE_OVERLOAD;
            len = ($urandom_range(0, 9) < 8) ? 1 : $urandom_range(0, 4);
        end
        else if (pick < 72)
        begin
            case ($urandom_range(0, 2))
                0:       code = CODE_ROUTER;
                1:       code = CODE_DNS;
                default: code = CODE_SERVER;
            endcase
            len = ($urandom_range(0, 9) < 7) ? 4 * $urandom_range(0, 3) : $urandom_range(0, 13);
        end
        else
        begin
            code = 8'($urandom_range(1, 254));
            len = ($urandom_range(0, 99) < 3) ? $urandom_range(200, 255) : $urandom_range(0, 10);
        end
        add_area_byte(code);
        add_area_byte(len[7:0]);
        repeat (len) add_area_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_random_area();
        int           last_at;
        int           i;
        logic         lead;
        area_ending_t ending;
        area_bytes.delete();
        repeat ($urandom_range(1, 6)) add_random_option();
        ending = area_ending_t'($urandom_range(0, 3));
        last_at = -1;
        case (ending)
            END_MARKED:
            begin
                add_area_byte(CODE_END);
                last_at = area_bytes.size() - 1;
            end
            END_THEN_TAIL:
            begin
                // bytes past the end marker must be ignored
                add_area_byte(CODE_END);
                repeat ($urandom_range(1, 3)) add_area_byte(8'($urandom_range(0, 255)));
                last_at = area_bytes.size() - 1;
            end
            END_CUT_SHORT:
                last_at = $urandom_range(0, area_bytes.size() - 1);
            default:
                if ($urandom_range(0, 1))
                    add_area_byte(CODE_END);
        endcase
        lead = ($urandom_range(0, 19) != 0);
        for (i = 0; i < area_bytes.size(); i++)
        begin
            send_area_byte(area_bytes[i], lead && i == 0, i == last_at);
            if (i == last_at)
                break;
        end
        areas_sent++;
    endtask

    task automatic send_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 10))
        begin
            b = ($urandom_range(0, 4) == 0) ? CODE_END : 8'($urandom_range(0, 255));
            send_area_byte(b, $urandom_range(0, 9) == 0, $urandom_range(0, 99) < 15);
        end
    endtask

    task automatic test_directed_areas();
        rx_mode = RX_PATTERN;
        gaps_enabled = 1'b1;
        // no area start after reset, cut short on the captured byte
        send_area_byte(CODE_MSG_TYPE, 1'b0, 1'b0);
        send_area_byte(8'd1, 1'b0, 1'b0);
        send_area_byte(8'h07, 1'b0, 1'b1);
        // one group of extreme bytes, then a trailing partial group
        send_area_byte(CODE_DNS, 1'b1, 1'b0);
        send_area_byte(8'd5, 1'b0, 1'b0);
        send_area_byte(8'h00, 1'b0, 1'b0);
        send_area_byte(8'hff, 1'b0, 1'b0);
        send_area_byte(8'h80, 1'b0, 1'b0);
        send_area_byte(8'h01, 1'b0, 1'b0);
        send_area_byte(8'haa, 1'b0, 1'b0);
        // zero length overload, then a real one
        send_area_byte(CODE_OVERLOAD, 1'b0, 1'b0);
        send_area_byte(8'd0, 1'b0, 1'b0);
        send_area_byte(CODE_OVERLOAD, 1'b0, 1'b0);
        send_area_byte(8'd1, 1'b0, 1'b0);
        send_area_byte(8'h80, 1'b0, 1'b0);
        // message type twice; latest wins, second data byte not captured
        send_area_byte(CODE_MSG_TYPE, 1'b0, 1'b0);
        send_area_byte(8'd1, 1'b0, 1'b0);
        send_area_byte(8'hff, 1'b0, 1'b0);
        send_area_byte(CODE_MSG_TYPE, 1'b0, 1'b0);
        send_area_byte(8'd2, 1'b0, 1'b0);
        send_area_byte(8'h02, 1'b0, 1'b0);
        send_area_byte(8'h99, 1'b0, 1'b0);
        send_area_byte(CODE_END, 1'b0, 1'b1);
        send_area_byte(CODE_ROUTER, 1'b0, 1'b1);
        // address and summary from the same byte
        send_area_byte(CODE_SERVER, 1'b1, 1'b0);
        send_area_byte(8'd4, 1'b0, 1'b0);
        send_area_byte(8'h0a, 1'b0, 1'b0);
        send_area_byte(8'h0b, 1'b0, 1'b0);
        send_area_byte(8'h0c, 1'b0, 1'b0);
        send_area_byte(8'h0d, 1'b0, 1'b1);
        wait_results_drained();
    endtask

    // Receiver holds off while a long router list keeps the input busy.
    task automatic test_full_queue();
        rx_mode = RX_NONE;
        gaps_enabled = 1'b0;
        hold_requests++;
        send_area_byte(CODE_ROUTER, 1'b1, 1'b0);
        send_area_byte(8'd252, 1'b0, 1'b0);
        repeat (252) send_area_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_area_byte(CODE_END, 1'b0, 1'b1);
        wait_results_drained();
    endtask

    task automatic test_random_areas();
        int target;
        int rounds;
        target = scanned_bytes + RANDOM_ITEMS;
        rounds = 0;
        while (scanned_bytes < target)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            gaps_enabled = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 99) < 15)
                send_noise();
            else
                send_random_area();
            rounds++;
            if (rounds % 30 == 0)
                wait_results_drained();
        end
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        test_directed_areas();
        test_full_queue();
        test_random_areas();
        wait_results_drained();
        if (pending_scan_results.size() != 0)
            report_mismatch("results never delivered", pending_scan_results.size(), 32'd0);
        $display("Scanned %0d bytes over %0d random areas; checked %0d addresses, %0d summaries",
                 scanned_bytes, areas_sent, address_results, summary_results);
        $display("Input held off for %0d cycles by back-pressure; %0d mismatches",
                 stalled_input_cycles, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
